// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files of the matrix element select unit
// expects signals named clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/smes_pkg.sv =====
// types and constants of the sparse matrix element select unit
// no dependencies; used by smes_store and the top level
package smes_pkg;

    localparam int DIM_W    = 7;
    localparam int VAL_W    = 32;
    localparam int NZ_W     = 11;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    localparam logic LAYOUT_COORD = 1'b0;
    localparam logic LAYOUT_ARRAY = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OOB   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_WHOLE = 2'd3;

    // register index, taken from paddr above the byte offset
    localparam logic [ADDR_W-3:0] REG_NUM_ROWS      = 2'd0;
    localparam logic [ADDR_W-3:0] REG_NUM_COLS      = 2'd1;
    localparam logic [ADDR_W-3:0] REG_LAYOUT        = 2'd2;
    localparam logic [ADDR_W-3:0] REG_NONZERO_COUNT = 2'd3;

    typedef struct packed {
        logic             command;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [VAL_W-1:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [VAL_W-1:0]    data;
        logic                present;
        logic [DIM_W-1:0]    out_row;
        logic [DIM_W-1:0]    out_col;
        logic [STATUS_W-1:0] status;
        logic                last;
    } out_beat_t;

    typedef struct packed {
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REPORT,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

endpackage

// ===== hw/rtl/smes_store.sv =====
// entry store: one write port that appends at the fill count, one sync read port
// depends on smes_pkg and assert_macros.svh
`include "assert_macros.svh"

module smes_store #(
    parameter int MAX_ENTRIES = 1024,
    localparam int AW = $clog2(MAX_ENTRIES),
    localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  smes_pkg::entry_t  wr_entry,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output smes_pkg::entry_t  rd_entry,
    output logic [CW-1:0]     loaded_count,
    output logic              full
);
    import smes_pkg::*;

    entry_t        mem [MAX_ENTRIES];
    entry_t        rd_entry_reg;
    logic [CW-1:0] count_reg;
    logic          do_write;

    assign full         = (count_reg == CW'(MAX_ENTRIES));
    assign do_write     = wr_en && !full;
    assign loaded_count = count_reg;
    assign rd_entry     = rd_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (do_write)
        begin
            count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[count_reg[AW-1:0]] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    `ASSERT_CLK(a_count_bound, count_reg <= CW'(MAX_ENTRIES), "fill count past store depth")
    `ASSERT_NEXT(a_count_step, do_write, count_reg == $past(count_reg) + CW'(1), "fill count did not advance")

endmodule

// ===== hw/rtl/sparse_matrix_element_select_unit.sv =====
// Matrix element select unit. Load beats append one entry each to an entry store of
// MAX_ENTRIES words and return no result; a load into a full store returns one result
// with status 2. A select beat names a row and a column (0 = all along that axis) and
// returns one result per position in row then column order, last set on the final one;
// out-of-bounds and whole-matrix selects return a single flagged result.
// In coordinate layout a select first scans min(nonzero_count, loaded entries) entries
// through the single read port of the entry store, one entry per cycle, collecting
// first matches into a per-position buffer; then each result passes through a buffer
// read and an output load. In array layout each result passes through an entry store
// read and an output load. The next beat is taken once the last result is in the
// output register. Stores have no reset and need no clearing pass.
// depends on smes_pkg, smes_store and assert_macros.svh
`include "assert_macros.svh"

module sparse_matrix_element_select_unit #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_DIM     = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [smes_pkg::ADDR_W-1:0] paddr,
    input  logic [smes_pkg::DATA_W-1:0] pwdata,
    output logic [smes_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  smes_pkg::in_beat_t          in_beat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output smes_pkg::out_beat_t         out_beat
);
    import smes_pkg::*;

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int PW   = $clog2(MAX_DIM);
    localparam int MW   = (CW > NZ_W) ? CW : NZ_W;
    localparam int AD_W = 2 * DIM_W;
    localparam int XW   = (CW > AD_W) ? CW : AD_W;

    // configuration
    logic [DIM_W-1:0] num_rows_reg;
    logic [DIM_W-1:0] num_cols_reg;
    logic             layout_reg;
    logic [NZ_W-1:0]  nonzero_count_reg;
    logic             cfg_wr;
    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nc;

    // control
    state_t                state_reg;
    state_t                state_next;
    logic [DIM_W-1:0]      sel_row_reg;
    logic [DIM_W-1:0]      sel_col_reg;
    logic [STATUS_W-1:0]   rpt_status_reg;
    logic [CW-1:0]         scan_idx_reg;
    logic [CW-1:0]         scan_len_reg;
    logic [CW-1:0]         scan_len_next;
    logic                  rd_valid_reg;
    logic [MAX_DIM-1:0]    found_reg;
    logic [PW-1:0]         pos_reg;
    logic [PW-1:0]         pos_end_reg;
    logic [PW-1:0]         pos_start;
    logic [PW-1:0]         pos_end;
    logic                  present_reg;
    logic                  out_valid_reg;
    out_beat_t             out_beat_reg;
    out_beat_t             out_beat_next;
    logic                  out_load;
    logic                  out_free;

    // decode of the incoming beat
    logic             in_acc;
    logic             is_load;
    logic             sel_oob;
    logic             sel_whole;
    logic [DIM_W-1:0] in_col_m1;
    logic [DIM_W-1:0] nr_m1;
    logic [DIM_W-1:0] nc_m1;
    logic [MW-1:0]    nz_ext;
    logic [MW-1:0]    ld_ext;

    // entry store
    logic          st_wr_en;
    entry_t        st_wr_entry;
    logic          st_rd_en;
    logic [AW-1:0] st_rd_addr;
    entry_t        st_rd_entry;
    logic [CW-1:0] loaded_count;
    logic          store_full;

    // scan
    logic             scan_issue;
    logic             scan_hit;
    logic             e_row_ok;
    logic             e_col_ok;
    logic [DIM_W-1:0] e_row_m1;
    logic [DIM_W-1:0] e_col_m1;
    logic [PW-1:0]    slot_idx;

    // per-position buffer of first matches
    logic [VAL_W-1:0] slot_mem [MAX_DIM];
    logic [VAL_W-1:0] slot_rdata_reg;
    logic             slot_rd_en;

    // emission position
    logic [DIM_W-1:0] cur_row;
    logic [DIM_W-1:0] cur_col;
    logic [AD_W-1:0]  arr_addr;
    logic [XW-1:0]    arr_addr_x;
    logic             arr_hit;
    logic             pos_last;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg      <= DIM_W'(1);
            num_cols_reg      <= DIM_W'(1);
            layout_reg        <= LAYOUT_COORD;
            nonzero_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[ADDR_W-1:2])
                REG_NUM_ROWS:      num_rows_reg      <= pwdata[DIM_W-1:0];
                REG_NUM_COLS:      num_cols_reg      <= pwdata[DIM_W-1:0];
                REG_LAYOUT:        layout_reg        <= pwdata[0];
                REG_NONZERO_COUNT: nonzero_count_reg <= pwdata[NZ_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[ADDR_W-1:2])
            REG_NUM_ROWS:      prdata = DATA_W'(num_rows_reg);
            REG_NUM_COLS:      prdata = DATA_W'(num_cols_reg);
            REG_LAYOUT:        prdata = DATA_W'(layout_reg);
            REG_NONZERO_COUNT: prdata = DATA_W'(nonzero_count_reg);
            default:           prdata = '0;
        endcase
    end

    // dimensions in use, held to 1..MAX_DIM
    always_comb
    begin
        if (num_rows_reg == '0)
            nr = DIM_W'(1);
        else if (num_rows_reg > DIM_W'(MAX_DIM))
            nr = DIM_W'(MAX_DIM);
        else
            nr = num_rows_reg;

        if (num_cols_reg == '0)
            nc = DIM_W'(1);
        else if (num_cols_reg > DIM_W'(MAX_DIM))
            nc = DIM_W'(MAX_DIM);
        else
            nc = num_cols_reg;
    end

    // ---------------- input decode ----------------
    assign in_acc    = in_valid && in_ready;
    assign is_load   = (in_beat.command == CMD_LOAD);
    assign sel_oob   = (in_beat.row > nr) || (in_beat.col > nc);
    assign sel_whole = (in_beat.row == '0) && (in_beat.col == '0);
    assign in_col_m1 = in_beat.col - DIM_W'(1);
    assign nr_m1     = nr - DIM_W'(1);
    assign nc_m1     = nc - DIM_W'(1);

    assign nz_ext = MW'(nonzero_count_reg);
    assign ld_ext = MW'(loaded_count);
    assign scan_len_next = (nz_ext < ld_ext) ? CW'(nonzero_count_reg) : loaded_count;

    // a single-axis select walks the free axis; a point select sits on its column
    always_comb
    begin
        if (in_beat.row != '0 && in_beat.col != '0)
            pos_start = in_col_m1[PW-1:0];
        else
            pos_start = '0;

        if (in_beat.row == '0)
            pos_end = nr_m1[PW-1:0];
        else if (in_beat.col == '0)
            pos_end = nc_m1[PW-1:0];
        else
            pos_end = in_col_m1[PW-1:0];
    end

    // ---------------- entry store ----------------
    smes_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (st_wr_en),
        .wr_entry     (st_wr_entry),
        .rd_en        (st_rd_en),
        .rd_addr      (st_rd_addr),
        .rd_entry     (st_rd_entry),
        .loaded_count (loaded_count),
        .full         (store_full)
    );

    always_comb
    begin
        st_wr_entry.value = in_beat.value;
        if (layout_reg == LAYOUT_ARRAY)
        begin
            st_wr_entry.row = '0;
            st_wr_entry.col = '0;
        end
        else
        begin
            st_wr_entry.row = in_beat.row;
            st_wr_entry.col = in_beat.col;
        end
    end

    // ---------------- scan datapath ----------------
    assign scan_issue = (state_reg == ST_SCAN) && (scan_idx_reg != scan_len_reg);

    assign e_row_m1 = st_rd_entry.row - DIM_W'(1);
    assign e_col_m1 = st_rd_entry.col - DIM_W'(1);
    assign e_row_ok = (st_rd_entry.row != '0) && (st_rd_entry.row <= nr);
    assign e_col_ok = (st_rd_entry.col != '0) && (st_rd_entry.col <= nc);
    assign slot_idx = (sel_row_reg == '0) ? e_row_m1[PW-1:0] : e_col_m1[PW-1:0];

    // only the first matching entry of a position is kept
    assign scan_hit = rd_valid_reg && e_row_ok && e_col_ok
                   && (sel_row_reg == '0 || st_rd_entry.row == sel_row_reg)
                   && (sel_col_reg == '0 || st_rd_entry.col == sel_col_reg)
                   && !found_reg[slot_idx];

    // ---------------- emission datapath ----------------
    assign cur_row  = (sel_row_reg == '0) ? DIM_W'(pos_reg) + DIM_W'(1) : sel_row_reg;
    assign cur_col  = (sel_row_reg == '0) ? sel_col_reg : DIM_W'(pos_reg) + DIM_W'(1);
    assign pos_last = (pos_reg == pos_end_reg);

    // column-major address of the current position
    assign arr_addr   = AD_W'(cur_col - DIM_W'(1)) * AD_W'(nr) + AD_W'(cur_row - DIM_W'(1));
    assign arr_addr_x = XW'(arr_addr);
    assign arr_hit    = arr_addr_x < XW'(loaded_count);

    assign slot_rd_en = (state_reg == ST_EMIT_RD) && (layout_reg == LAYOUT_COORD);
    assign out_free   = !out_valid_reg || out_ready;

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (is_load)
                        state_next = store_full ? ST_REPORT : ST_IDLE;
                    else if (sel_oob || sel_whole)
                        state_next = ST_REPORT;
                    else if (layout_reg == LAYOUT_ARRAY)
                        state_next = ST_EMIT_RD;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // the last entry is checked at the same edge that leaves the scan
                if (scan_idx_reg == scan_len_reg)
                    state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (out_free)
                    state_next = pos_last ? ST_IDLE : ST_EMIT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        st_wr_en      = 1'b0;
        st_rd_en      = 1'b0;
        st_rd_addr    = scan_idx_reg[AW-1:0];
        out_load      = 1'b0;
        out_beat_next = out_beat_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                st_wr_en = in_acc && is_load && !store_full;
            end
            ST_REPORT:
            begin
                out_load              = out_free;
                out_beat_next.data    = '0;
                out_beat_next.present = 1'b0;
                out_beat_next.out_row = sel_row_reg;
                out_beat_next.out_col = sel_col_reg;
                out_beat_next.status  = rpt_status_reg;
                out_beat_next.last    = 1'b1;
            end
            ST_SCAN:
            begin
                st_rd_en   = scan_issue;
                st_rd_addr = scan_idx_reg[AW-1:0];
            end
            ST_EMIT_RD:
            begin
                st_rd_en   = (layout_reg == LAYOUT_ARRAY) && arr_hit;
                st_rd_addr = arr_addr_x[AW-1:0];
            end
            ST_EMIT_WR:
            begin
                out_load = out_free;
                if (!present_reg)
                    out_beat_next.data = '0;
                else if (layout_reg == LAYOUT_ARRAY)
                    out_beat_next.data = st_rd_entry.value;
                else
                    out_beat_next.data = slot_rdata_reg;
                out_beat_next.present = present_reg;
                out_beat_next.out_row = cur_row;
                out_beat_next.out_col = cur_col;
                out_beat_next.status  = STATUS_OK;
                out_beat_next.last    = pos_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= scan_issue;
            if (in_acc && !is_load)
                found_reg <= '0;
            else if (scan_hit)
                found_reg[slot_idx] <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sel_row_reg  <= in_beat.row;
            sel_col_reg  <= in_beat.col;
            scan_idx_reg <= '0;
            scan_len_reg <= scan_len_next;
            pos_reg      <= pos_start;
            pos_end_reg  <= pos_end;
            if (is_load)
                rpt_status_reg <= STATUS_FULL;
            else if (sel_oob)
                rpt_status_reg <= STATUS_OOB;
            else
                rpt_status_reg <= STATUS_WHOLE;
        end
        if (scan_issue)
            scan_idx_reg <= scan_idx_reg + CW'(1);
        if (state_reg == ST_EMIT_RD)
            present_reg <= (layout_reg == LAYOUT_ARRAY) ? arr_hit : found_reg[pos_reg];
        if (state_reg == ST_EMIT_WR && out_free && !pos_last)
            pos_reg <= pos_reg + PW'(1);
        if (out_load)
            out_beat_reg <= out_beat_next;
    end

    always_ff @(posedge clk)
    begin
        if (scan_hit)
            slot_mem[slot_idx] <= st_rd_entry.value;
        if (slot_rd_en)
            slot_rdata_reg <= slot_mem[pos_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    `ASSERT_CLK(a_read_in_scan, !rd_valid_reg || state_reg == ST_SCAN, "scan read outside scan")
    `ASSERT_CLK(a_scan_bound, state_reg != ST_SCAN || scan_idx_reg <= scan_len_reg, "scan past length")
    `ASSERT_CLK(a_pos_bound, (state_reg != ST_EMIT_RD && state_reg != ST_EMIT_WR) || pos_reg <= pos_end_reg, "position past end")
    `ASSERT_NEXT(a_last_idle, out_load && out_beat_next.last, state_reg == ST_IDLE, "last beat without return to idle")

endmodule

// ===== tb/tb_sparse_matrix_element_select_unit.sv =====
// testbench for sparse_matrix_element_select_unit: directed script, then random load/select traffic
// checked beat by beat against an in-bench model of the entry store and lookup
// depends on smes_pkg and the rtl of the unit
`timescale 1ns / 100ps

module tb_sparse_matrix_element_select_unit;

    import smes_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int DIM_LIMIT   = 64;
    localparam int SETTLE      = 16;

    typedef enum logic {
        SCRIPT_REG,
        SCRIPT_BEAT
    } script_kind_t;

    typedef struct packed {
        script_kind_t        kind;
        logic [ADDR_W-3:0]   reg_idx;
        logic [DATA_W-1:0]   reg_val;
        in_beat_t            beat;
        logic                typed;
        out_beat_t           result;
    } script_row_t;

    typedef struct packed {
        logic      typed;
        out_beat_t result;
    } beat_note_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    in_beat_t            in_beat   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_beat_t           out_beat;

    // model of the unit: entry store and register copies
    logic [DIM_W-1:0]    entry_rows   [STORE_DEPTH];
    logic [DIM_W-1:0]    entry_cols   [STORE_DEPTH];
    logic [VAL_W-1:0]    entry_values [STORE_DEPTH];
    int                  loaded_entries = 0;
    logic [DIM_W-1:0]    cfg_num_rows = 7'd1;
    logic [DIM_W-1:0]    cfg_num_cols = 7'd1;
    logic                cfg_layout   = LAYOUT_COORD;
    logic [NZ_W-1:0]     cfg_nonzero  = '0;

    out_beat_t           step_results[$];
    out_beat_t           expected_results[$];
    beat_note_t          beat_notes[$];
    int                  mismatch_count = 0;
    logic                no_idle = 1'b0;

    sparse_matrix_element_select_unit #(
        .MAX_ENTRIES(STORE_DEPTH),
        .MAX_DIM    (DIM_LIMIT)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_beat  (in_beat),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_beat (out_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 200)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    function automatic int clamp_dim(input logic [DIM_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > DIM_LIMIT)
            return DIM_LIMIT;
        return int'(d);
    endfunction

    function automatic void find_entry(input int r, input int c, input int nr,
                                       output logic [VAL_W-1:0] data, output logic present);
        int addr;
        int span;
        data = '0;
        present = 1'b0;
        if (cfg_layout == LAYOUT_ARRAY)
        begin
            // column-major address over the values loaded so far
            addr = (c - 1) * nr + (r - 1);
            if (addr < loaded_entries)
            begin
                data = entry_values[addr];
                present = 1'b1;
            end
        end
        else
        begin
            span = (cfg_nonzero < loaded_entries) ? int'(cfg_nonzero) : loaded_entries;
            for (int i = 0; i < span && !present; i++)
                if (entry_rows[i] == r && entry_cols[i] == c)
                begin
                    data = entry_values[i];
                    present = 1'b1;
                end
        end
    endfunction

    function automatic void predict_beat(input in_beat_t b);
        int nr;
        int nc;
        int r0;
        int r1;
        int c0;
        int c1;
        out_beat_t res;
        logic [VAL_W-1:0] d;
        logic p;
        step_results.delete();
        nr = clamp_dim(cfg_num_rows);
        nc = clamp_dim(cfg_num_cols);
        res = '0;
        res.last = 1'b1;
        if (b.command == CMD_LOAD)
        begin
            if (loaded_entries >= STORE_DEPTH)
            begin
                res.out_row = b.row;
                res.out_col = b.col;
                res.status = STATUS_FULL;
                step_results.push_back(res);
            end
            else
            begin
                entry_rows[loaded_entries] = (cfg_layout == LAYOUT_ARRAY) ? '0 : b.row;
                entry_cols[loaded_entries] = (cfg_layout == LAYOUT_ARRAY) ? '0 : b.col;
                entry_values[loaded_entries] = b.value;
                loaded_entries++;
            end
        end
        else if (b.row > nr || b.col > nc)
        begin
            res.out_row = b.row;
            res.out_col = b.col;
            res.status = STATUS_OOB;
            step_results.push_back(res);
        end
        else if (b.row == 0 && b.col == 0)
        begin
            res.status = STATUS_WHOLE;
            step_results.push_back(res);
        end
        else
        begin
            r0 = (b.row != 0) ? int'(b.row) : 1;
            r1 = (b.row != 0) ? int'(b.row) : nr;
            c0 = (b.col != 0) ? int'(b.col) : 1;
            c1 = (b.col != 0) ? int'(b.col) : nc;
            for (int r = r0; r <= r1; r++)
                for (int c = c0; c <= c1; c++)
                begin
                    find_entry(r, c, nr, d, p);
                    res = '0;
                    res.data = d;
                    res.present = p;
                    res.out_row = r[DIM_W-1:0];
                    res.out_col = c[DIM_W-1:0];
                    res.status = STATUS_OK;
                    res.last = (r == r1) && (c == c1);
                    step_results.push_back(res);
                end
        end
    endfunction

    task automatic check_result(input out_beat_t got);
        out_beat_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result beat with nothing pending, data", got.data, '0);
            return;
        end
        want = expected_results.pop_front();
        if (got.data !== want.data)
            report_mismatch("data", got.data, want.data);
        if (got.present !== want.present)
            report_mismatch("present", 32'(got.present), 32'(want.present));
        if (got.out_row !== want.out_row)
            report_mismatch("out_row", 32'(got.out_row), 32'(want.out_row));
        if (got.out_col !== want.out_col)
            report_mismatch("out_col", 32'(got.out_col), 32'(want.out_col));
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.last !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    // accepted input beats feed the model, accepted result beats are checked
    always @(posedge clk)
    begin : monitor
        beat_note_t note;
        if (rst_n && in_valid && in_ready)
        begin
            note = beat_notes.pop_front();
            predict_beat(in_beat);
            if (note.typed)
                expected_results.push_back(note.result);
            else
                foreach (step_results[i])
                    expected_results.push_back(step_results[i]);
        end
        if (rst_n && out_valid && out_ready)
            check_result(out_beat);
    end

    always @(negedge clk)
        out_ready <= no_idle || ($urandom_range(99) >= 36);

    // called on a falling edge, returns on the falling edge after the beat is taken
    task automatic send_beat(input in_beat_t b, input logic typed, input out_beat_t result);
        beat_note_t note;
        note.typed = typed;
        note.result = result;
        while (!no_idle && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        beat_notes.push_back(note);
        in_valid <= 1'b1;
        in_beat <= b;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // loads leave nothing pending, so let the unit settle after the last result
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [ADDR_W-3:0] idx, input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] readback;
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_NUM_ROWS:      cfg_num_rows = val[DIM_W-1:0];
            REG_NUM_COLS:      cfg_num_cols = val[DIM_W-1:0];
            REG_LAYOUT:        cfg_layout = val[0];
            REG_NONZERO_COUNT: cfg_nonzero = val[NZ_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== val)
            report_mismatch("register readback", readback, val);
    endtask

    function automatic script_row_t reg_row(input logic [ADDR_W-3:0] idx, input int val);
        script_row_t s;
        s = '0;
        s.kind = SCRIPT_REG;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic script_row_t beat_row(input logic cmd, input int r, input int c,
                                             input logic [VAL_W-1:0] v);
        script_row_t s;
        s = '0;
        s.kind = SCRIPT_BEAT;
        s.beat.command = cmd;
        s.beat.row = r[DIM_W-1:0];
        s.beat.col = c[DIM_W-1:0];
        s.beat.value = v;
        return s;
    endfunction

    // single-result select whose outcome is plain: position echoed, no data
    function automatic script_row_t flagged_row(input int r, input int c,
                                                input logic [STATUS_W-1:0] st);
        script_row_t s;
        s = beat_row(CMD_SELECT, r, c, 32'hdead_beef);
        s.typed = 1'b1;
        s.result.out_row = r[DIM_W-1:0];
        s.result.out_col = c[DIM_W-1:0];
        s.result.status = st;
        s.result.last = 1'b1;
        return s;
    endfunction

    task automatic play_row(input script_row_t s);
        if (s.kind == SCRIPT_REG)
            write_register(s.reg_idx, s.reg_val);
        else
            send_beat(s.beat, s.typed, s.result);
    endtask

    function automatic in_beat_t random_beat();
        in_beat_t b;
        int nr;
        int nc;
        int pick;
        nr = clamp_dim(cfg_num_rows);
        nc = clamp_dim(cfg_num_cols);
        b.value = $urandom;
        b.row = DIM_W'($urandom_range(nr, 1));
        b.col = DIM_W'($urandom_range(nc, 1));
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            b.command = CMD_LOAD;
            if ($urandom_range(9) == 0)
            begin
                b.row = DIM_W'($urandom_range(127));
                b.col = DIM_W'($urandom_range(127));
            end
        end
        else
        begin
            b.command = CMD_SELECT;
            pick = $urandom_range(99);
            if (pick < 12)
                b.row = '0;
            else if (pick < 24)
                b.col = '0;
            else if (pick < 28)
            begin
                b.row = '0;
                b.col = '0;
            end
            else if (pick < 36)
            begin
                b.row = DIM_W'($urandom_range(127));
                b.col = DIM_W'($urandom_range(127));
            end
        end
        return b;
    endfunction

    initial
    begin : stimulus
        script_row_t directed[$];
        in_beat_t b;
        int rows;
        int cols;
        int lay;
        int nnz;
        int fill;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset registers: 1x1, coordinate layout, empty search window
        directed.push_back(flagged_row(1, 1, STATUS_OK));
        directed.push_back(flagged_row(0, 0, STATUS_WHOLE));
        directed.push_back(flagged_row(2, 1, STATUS_OOB));
        directed.push_back(flagged_row(0, 127, STATUS_OOB));
        directed.push_back(beat_row(CMD_LOAD, 1, 1, 32'hffff_ffff));
        directed.push_back(flagged_row(1, 1, STATUS_OK));
        directed.push_back(reg_row(REG_NUM_ROWS, 64));
        directed.push_back(reg_row(REG_NUM_COLS, 64));
        directed.push_back(reg_row(REG_NONZERO_COUNT, STORE_DEPTH));
        // duplicate position: the first stored entry wins
        directed.push_back(beat_row(CMD_LOAD, 64, 64, 32'h0000_0000));
        directed.push_back(beat_row(CMD_LOAD, 64, 64, 32'h1234_5678));
        directed.push_back(beat_row(CMD_LOAD, 1, 64, 32'h8000_0001));
        directed.push_back(beat_row(CMD_LOAD, 127, 127, 32'h5555_aaaa));
        directed.push_back(beat_row(CMD_SELECT, 64, 64, 32'h0));
        directed.push_back(beat_row(CMD_SELECT, 1, 0, 32'h0));
        directed.push_back(beat_row(CMD_SELECT, 0, 64, 32'h0));
        directed.push_back(flagged_row(65, 1, STATUS_OOB));
        // array layout with dimension registers outside 1..64
        directed.push_back(reg_row(REG_LAYOUT, int'(LAYOUT_ARRAY)));
        directed.push_back(reg_row(REG_NUM_ROWS, 0));
        directed.push_back(reg_row(REG_NUM_COLS, 127));
        directed.push_back(beat_row(CMD_LOAD, 0, 0, 32'ha5a5_a5a5));
        directed.push_back(beat_row(CMD_SELECT, 1, 0, 32'h0));
        directed.push_back(beat_row(CMD_SELECT, 0, 3, 32'h0));
        directed.push_back(flagged_row(2, 1, STATUS_OOB));
        directed.push_back(flagged_row(1, 65, STATUS_OOB));
        foreach (directed[i])
            play_row(directed[i]);

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0)
            begin
                rows = 64;
                cols = 64;
                lay = int'(LAYOUT_COORD);
                nnz = STORE_DEPTH;
            end
            else if (ph == 1)
            begin
                rows = 1;
                cols = 1;
                lay = int'(LAYOUT_ARRAY);
                nnz = 0;
            end
            else
            begin
                rows = $urandom_range(6, 1);
                cols = $urandom_range(6, 1);
                lay = $urandom_range(1);
                case ($urandom_range(3))
                    0: nnz = 0;
                    1: nnz = $urandom_range(40);
                    2: nnz = STORE_DEPTH;
                    default: nnz = $urandom_range(2047);
                endcase
            end
            play_row(reg_row(REG_NUM_ROWS, rows));
            play_row(reg_row(REG_NUM_COLS, cols));
            play_row(reg_row(REG_LAYOUT, lay));
            play_row(reg_row(REG_NONZERO_COUNT, nnz));
            no_idle = (ph == 4);
            repeat (32) send_beat(random_beat(), 1'b0, '0);
            no_idle = 1'b0;
        end

        // fill the store to the top, then overflow it
        play_row(reg_row(REG_LAYOUT, int'(LAYOUT_COORD)));
        play_row(reg_row(REG_NUM_ROWS, 8));
        play_row(reg_row(REG_NUM_COLS, 8));
        play_row(reg_row(REG_NONZERO_COUNT, STORE_DEPTH));
        fill = STORE_DEPTH - loaded_entries;
        repeat (fill)
        begin
            b = random_beat();
            b.command = CMD_LOAD;
            send_beat(b, 1'b0, '0);
        end
        play_row(beat_row(CMD_LOAD, 0, 0, $urandom));
        play_row(beat_row(CMD_LOAD, 127, 127, $urandom));
        play_row(beat_row(CMD_LOAD, 0, 127, $urandom));
        play_row(beat_row(CMD_LOAD, 127, 0, $urandom));
        play_row(beat_row(CMD_SELECT, 0, 3, 32'h0));
        play_row(beat_row(CMD_SELECT, 2, 0, 32'h0));
        play_row(beat_row(CMD_SELECT, 5, 5, 32'h0));
        play_row(reg_row(REG_LAYOUT, int'(LAYOUT_ARRAY)));
        play_row(reg_row(REG_NUM_ROWS, 64));
        play_row(reg_row(REG_NUM_COLS, 64));
        play_row(beat_row(CMD_SELECT, 0, 16, 32'h0));
        play_row(beat_row(CMD_SELECT, 1, 0, 32'h0));
        play_row(beat_row(CMD_SELECT, 64, 64, 32'h0));
        play_row(beat_row(CMD_LOAD, 3, 3, $urandom));
        wait_idle();

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/smes_pkg.sv
hw/rtl/smes_store.sv
hw/rtl/sparse_matrix_element_select_unit.sv
tb/tb_sparse_matrix_element_select_unit.sv
